FILE: rtl/core/mip_chain_box_downsampler_macros.svh
`ifndef MIP_CHAIN_BOX_DOWNSAMPLER_MACROS_SVH
`define MIP_CHAIN_BOX_DOWNSAMPLER_MACROS_SVH
`ifndef SYNTHESIS
`define MCBD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define MCBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MCBD_ASSERT_IMPL(lbl, ante, cons, msg)
`define MCBD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/core/mcbd_pkg.sv
package mcbd_pkg;

  localparam int CH_W          = 8;
  localparam int LEVEL_W       = 4;
  localparam int CFG_W         = 4;
  localparam int ROW_W         = 11;
  localparam int APB_ADDR_W    = 4;
  localparam int APB_DATA_W    = 32;
  localparam int SIZE_LOG2_MIN = 2;
  localparam int SIZE_LOG2_MAX = 11;

  localparam logic [1:0] REG_WIDTH_LOG2  = 2'd0;
  localparam logic [1:0] REG_HEIGHT_LOG2 = 2'd1;
  localparam logic [1:0] REG_LEVELS      = 2'd2;

  localparam logic [CFG_W-1:0] WIDTH_LOG2_RST  = 4'd8;
  localparam logic [CFG_W-1:0] HEIGHT_LOG2_RST = 4'd8;
  localparam logic [CFG_W-1:0] LEVELS_RST      = 4'd6;

  typedef struct packed {
    logic [CFG_W-1:0] wl;
    logic [CFG_W-1:0] hl;
    logic [CFG_W-1:0] nl;
    logic             clear;
  } geom_t;

endpackage

FILE: rtl/core/mcbd_pix_if.sv
interface mcbd_pix_if;
  logic                      valid;
  logic                      ready;
  logic [mcbd_pkg::CH_W-1:0] red;
  logic [mcbd_pkg::CH_W-1:0] green;
  logic [mcbd_pkg::CH_W-1:0] blue;
  logic [mcbd_pkg::CH_W-1:0] alpha;

  modport source (output valid, red, green, blue, alpha, input ready);
  modport sink (input valid, red, green, blue, alpha, output ready);
endinterface

FILE: rtl/core/mcbd_res_if.sv
interface mcbd_res_if;
  logic                         valid;
  logic                         ready;
  logic [mcbd_pkg::LEVEL_W-1:0] mip_level;
  logic [mcbd_pkg::CH_W-1:0]    out_red;
  logic [mcbd_pkg::CH_W-1:0]    out_green;
  logic [mcbd_pkg::CH_W-1:0]    out_blue;
  logic [mcbd_pkg::CH_W-1:0]    out_alpha;
  logic                         last_of_run;

  modport source (output valid, mip_level, out_red, out_green, out_blue, out_alpha,
                  last_of_run, input ready);
  modport sink (input valid, mip_level, out_red, out_green, out_blue, out_alpha,
                last_of_run, output ready);
endinterface

FILE: rtl/core/mcbd_engine.sv
`include "mip_chain_box_downsampler_macros.svh"

module mcbd_engine #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_LEVELS = 9
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mcbd_pkg::geom_t   geom,
  mcbd_pix_if.sink          in_if,
  mcbd_res_if.source        out_if
);

  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int LIX_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int YW    = mcbd_pkg::ROW_W;
  localparam int CW    = mcbd_pkg::CH_W;
  localparam int SW    = CW + 1;
  localparam int LV    = mcbd_pkg::LEVEL_W;

  typedef logic [3:0][CW-1:0] pix_t;
  typedef logic [3:0][SW-1:0] pair_t;

  logic [AW-1:0] xpos_r [MAX_LEVELS];
  logic [YW-1:0] ypos_r [MAX_LEVELS];
  pix_t          hold_r [MAX_LEVELS];
  pair_t         mem [MAX_WIDTH];
  pair_t         rd_data_r;

  logic          b_valid_r;
  logic          b_cas_r;
  logic [LV-1:0] b_lvl_r;
  pix_t          b_left_r;
  pix_t          b_px_r;

  logic          out_valid_r;
  logic          out_last_r;
  logic [LV-1:0] out_lvl_r;
  pix_t          out_pix_r;

  logic             stall;
  logic             cas_pend;
  logic             in_ready;
  logic             in_acc;
  logic             issue;
  logic             active;
  logic [LV-1:0]    tok_lvl;
  logic [LV-1:0]    tok_lvl_inc;
  pix_t             tok_px;
  pix_t             b_avg;
  logic [LIX_W-1:0] li;
  logic [AW-1:0]    x;
  logic [YW-1:0]    y;
  pix_t             hold;
  logic [LV-1:0]    shift_w;
  logic [LV-1:0]    shift_h;
  logic [AW:0]      base_w;
  logic [AW:0]      lw;
  logic [YW:0]      lh;
  logic             x_end;
  logic             y_end;
  logic [AW-1:0]    idx;
  logic [AW-1:0]    x_nxt;
  logic [YW-1:0]    y_nxt;
  logic             mem_we;
  logic             mem_re;
  pair_t            wr_pair;

  assign stall    = b_valid_r & out_valid_r & ~out_if.ready;
  assign cas_pend = b_valid_r & b_cas_r;
  assign in_ready = ~stall & ~cas_pend;
  assign in_acc   = in_if.valid & in_ready;
  assign issue    = (cas_pend & ~stall) | in_acc;
  assign in_if.ready = in_ready;

  always_comb begin
    logic [CW+1:0] tot;
    for (int c = 0; c < 4; c++) begin
      tot = (CW+2)'(rd_data_r[c]) + (CW+2)'(b_left_r[c]) + (CW+2)'(b_px_r[c]);
      b_avg[c] = tot[CW+1:2];
    end
  end

  always_comb begin
    tok_lvl = cas_pend ? LV'(b_lvl_r + LV'(1)) : '0;
    tok_px  = cas_pend ? b_avg : {in_if.alpha, in_if.blue, in_if.green, in_if.red};
    tok_lvl_inc = LV'(tok_lvl + LV'(1));
    active  = issue & (tok_lvl < geom.nl);
    li      = tok_lvl[LIX_W-1:0];
    x       = xpos_r[li];
    y       = ypos_r[li];
    hold    = hold_r[li];
    shift_w = LV'(geom.wl - tok_lvl);
    shift_h = LV'(geom.hl - tok_lvl);
    base_w  = (AW+1)'(1) << geom.wl;
    lw      = (AW+1)'(1) << shift_w;
    lh      = (YW+1)'(1) << shift_h;
    x_end   = (x == AW'(lw - (AW+1)'(1)));
    y_end   = (y == YW'(lh - (YW+1)'(1)));
    idx     = AW'(base_w - lw + (AW+1)'(x >> 1));
    x_nxt   = x_end ? '0 : AW'(x + AW'(1));
    y_nxt   = x_end ? (y_end ? '0 : YW'(y + YW'(1))) : y;
    mem_we  = active & x[0] & ~y[0];
    mem_re  = active & x[0] & y[0];
    for (int c = 0; c < 4; c++) begin
      wr_pair[c] = SW'(hold[c]) + SW'(tok_px[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || geom.clear) begin
      for (int i = 0; i < MAX_LEVELS; i++) begin
        xpos_r[i] <= '0;
        ypos_r[i] <= '0;
      end
    end else if (active) begin
      xpos_r[li] <= x_nxt;
      ypos_r[li] <= y_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (active && !x[0]) begin
      hold_r[li] <= tok_px;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[idx] <= wr_pair;
    end
    if (mem_re) begin
      rd_data_r <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      b_cas_r   <= 1'b0;
    end else if (!stall) begin
      b_valid_r <= mem_re;
      b_cas_r   <= tok_lvl_inc < geom.nl;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      b_lvl_r  <= tok_lvl;
      b_left_r <= hold;
      b_px_r   <= tok_px;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (b_valid_r && !stall) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid_r && !stall) begin
      out_lvl_r  <= LV'(b_lvl_r + LV'(1));
      out_pix_r  <= b_avg;
      out_last_r <= ~(b_cas_r & mem_re);
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.mip_level   = out_lvl_r;
  assign out_if.out_red     = out_pix_r[0];
  assign out_if.out_green   = out_pix_r[1];
  assign out_if.out_blue    = out_pix_r[2];
  assign out_if.out_alpha   = out_pix_r[3];
  assign out_if.last_of_run = out_last_r;

  `MCBD_ASSERT_NEXT(a_read_loads_avg, mem_re && !stall, b_valid_r, "line read lost its word")
  `MCBD_ASSERT_NEXT(a_stall_holds_avg, stall, b_valid_r && $stable(b_lvl_r), "stalled word moved")
  `MCBD_ASSERT_IMPL(a_avg_level_range, b_valid_r, b_lvl_r < geom.nl, "level beyond chain")
  `MCBD_ASSERT_IMPL(a_cascade_blocks_in, cas_pend, !in_acc, "input taken during cascade")

endmodule

FILE: rtl/core/mip_chain_box_downsampler.sv
// Each result of every level is registered in the average stage, then in the output register.
// Throughput: one pixel per cycle while the output is not stalled; a pixel that finishes a
// block below the deepest level holds the input while its average passes on to each further
// level in turn, since the single port of the line store is shared by all levels.
// Reset (rst_n low, synchronous): positions and handshakes clear, registers load 8, 8, 6;
// the line store keeps its contents, each entry is written before it is read.
module mip_chain_box_downsampler #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_LEVELS = 9
) (
  input  logic                                clk,
  input  logic                                rst_n,
  mcbd_pix_if.sink                            in_if,
  mcbd_res_if.source                          out_if,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mcbd_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [mcbd_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [mcbd_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int CFW     = mcbd_pkg::CFG_W;
  localparam int FLOOR_W = $clog2(MAX_WIDTH + 1) - 1;
  localparam int WL_CAP  = (FLOOR_W < mcbd_pkg::SIZE_LOG2_MAX) ? FLOOR_W
                                                               : mcbd_pkg::SIZE_LOG2_MAX;
  localparam logic [CFW-1:0] WL_CAP_V  = CFW'(WL_CAP);
  localparam logic [CFW-1:0] ML_V      = CFW'(MAX_LEVELS);
  localparam logic [CFW-1:0] LOG2_MIN  = CFW'(mcbd_pkg::SIZE_LOG2_MIN);
  localparam logic [CFW-1:0] LOG2_MAX  = CFW'(mcbd_pkg::SIZE_LOG2_MAX);

  logic [CFW-1:0]  width_log2_r;
  logic [CFW-1:0]  height_log2_r;
  logic [CFW-1:0]  levels_r;
  logic            cfg_wr;
  logic [1:0]      reg_idx;
  logic            reg_ok;
  logic [CFW-1:0]  wl_c;
  logic [CFW-1:0]  hl_c;
  logic [CFW-1:0]  nl_c;
  mcbd_pkg::geom_t geom;

  function automatic logic [CFW-1:0] clamp_log2(input logic [CFW-1:0] v);
    logic [CFW-1:0] r;
    r = v;
    if (v < LOG2_MIN) r = LOG2_MIN;
    if (v > LOG2_MAX) r = LOG2_MAX;
    return r;
  endfunction

  assign cfg_wr  = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];
  assign reg_ok  = (reg_idx == mcbd_pkg::REG_WIDTH_LOG2) ||
                   (reg_idx == mcbd_pkg::REG_HEIGHT_LOG2) ||
                   (reg_idx == mcbd_pkg::REG_LEVELS);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_log2_r  <= mcbd_pkg::WIDTH_LOG2_RST;
      height_log2_r <= mcbd_pkg::HEIGHT_LOG2_RST;
      levels_r      <= mcbd_pkg::LEVELS_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        mcbd_pkg::REG_WIDTH_LOG2:  width_log2_r  <= pwdata[CFW-1:0];
        mcbd_pkg::REG_HEIGHT_LOG2: height_log2_r <= pwdata[CFW-1:0];
        mcbd_pkg::REG_LEVELS:      levels_r      <= pwdata[CFW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      mcbd_pkg::REG_WIDTH_LOG2:  prdata = mcbd_pkg::APB_DATA_W'(width_log2_r);
      mcbd_pkg::REG_HEIGHT_LOG2: prdata = mcbd_pkg::APB_DATA_W'(height_log2_r);
      mcbd_pkg::REG_LEVELS:      prdata = mcbd_pkg::APB_DATA_W'(levels_r);
      default:                   prdata = '0;
    endcase
  end

  always_comb begin
    wl_c = clamp_log2(width_log2_r);
    if (wl_c > WL_CAP_V) wl_c = WL_CAP_V;
    hl_c = clamp_log2(height_log2_r);
    nl_c = levels_r;
    if (nl_c > ML_V) nl_c = ML_V;
    if (nl_c > wl_c) nl_c = wl_c;
    if (nl_c > hl_c) nl_c = hl_c;
    geom.wl    = wl_c;
    geom.hl    = hl_c;
    geom.nl    = nl_c;
    geom.clear = cfg_wr & reg_ok;
  end

  mcbd_engine #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_LEVELS (MAX_LEVELS)
  ) u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .geom   (geom),
    .in_if  (in_if),
    .out_if (out_if)
  );

endmodule
